// ===== hdl/pnc_pkg.sv =====
package pnc_pkg;

  // Width of the number under test; input bits above it are ignored
  localparam int unsigned NUMBER_WIDTH = 16;
  // Fixed stream payload widths
  localparam int unsigned IN_TDATA_WIDTH  = 16;
  localparam int unsigned SUM_WIDTH       = 18;
  localparam int unsigned OUT_TDATA_WIDTH = 24;
  // Accumulator is wide enough for any aliquot sum of an NUMBER_WIDTH-bit number
  localparam int unsigned ACC_WIDTH = 2 * NUMBER_WIDTH;
  // Divider step counter must hold NUMBER_WIDTH itself
  localparam int unsigned CNT_WIDTH = $clog2(NUMBER_WIDTH + 1);

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

  // Request to the serial divider
  typedef struct packed {
    logic                    start;
    logic [NUMBER_WIDTH-1:0] dividend;
    logic [NUMBER_WIDTH-1:0] divisor;
  } div_req_t;

  // Response from the serial divider
  typedef struct packed {
    logic                    done;
    logic [NUMBER_WIDTH-1:0] quotient;
    logic                    rem_zero;
  } div_rsp_t;

endpackage

// ===== hdl/pnc_div.sv =====
module pnc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pnc_pkg::div_req_t req_i,
  output pnc_pkg::div_rsp_t rsp_o
);
  import pnc_pkg::*;

  logic [NUMBER_WIDTH-1:0] rem_q, rem_d;
  logic [NUMBER_WIDTH-1:0] quo_q, quo_d;
  logic [NUMBER_WIDTH-1:0] dvs_q, dvs_d;
  logic [CNT_WIDTH-1:0]    cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [NUMBER_WIDTH:0]   rem_shift;
  logic [NUMBER_WIDTH:0]   diff;

  // One restoring step: shift in the next dividend bit, try to subtract
  assign rem_shift = {rem_q, quo_q[NUMBER_WIDTH-1]};
  assign diff      = rem_shift - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // Load operands and start a fresh division
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = CNT_WIDTH'(NUMBER_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUMBER_WIDTH-2:0], ~diff[NUMBER_WIDTH]};
      if (!diff[NUMBER_WIDTH]) begin
        rem_d = diff[NUMBER_WIDTH-1:0];
      end else begin
        rem_d = rem_shift[NUMBER_WIDTH-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_WIDTH'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

// ===== hdl/perfect_number_checker.sv =====
// Perfect number checker.
// Slave stream: s_axis_tdata_i carries one unsigned number per request; only
// the low NUMBER_WIDTH bits are used. Master stream: m_axis_tdata_o carries
// the aliquot sum (saturated to 18 bits) and a flag set when the number is
// nonzero and equals that sum. Exactly one result leaves for each request.
// Operation: trial divisors d = 1, 2, ... are run through one shared serial
// restoring divider, one quotient bit per cycle. The run stops at the first d
// whose quotient falls below d, i.e. once d*d exceeds the number; divisor
// pairs (d, n/d) are summed along the way.
// Each trial divisor takes a start state and a full pass of the divider
// before its result is checked in the run state. Numbers 0 and 1 skip the
// divider and go straight to the finish state. The next request can be
// taken in the same cycle as the result appears.
// One request is processed at a time; s_axis_tready_o is high only while the
// sequencer is idle. A finished result sits in an output register, so the
// next request is taken while the receiver stalls; a second result then waits
// until the first one is taken.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the sequencer to idle.
module perfect_number_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // number [15:0]
  input  logic [pnc_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // divisor_sum [17:0], is_perfect [18], zero [23:19]
  output logic [pnc_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i
);
  import pnc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_RUN   = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [NUMBER_WIDTH-1:0] num_q, num_d;
  logic [NUMBER_WIDTH-1:0] dvs_q, dvs_d;
  logic [ACC_WIDTH-1:0]    acc_q, acc_d;
  logic [SUM_WIDTH-1:0]    sum_out_q, sum_out_d;
  logic                    perf_out_q, perf_out_d;
  logic                    out_valid_q, out_valid_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [NUMBER_WIDTH-1:0]        in_num;
  logic [NUMBER_WIDTH:0]          term_lo, term_hi, term;
  logic [ACC_WIDTH+SUM_WIDTH-1:0] acc_ext;
  logic                           out_free;

  assign in_num = NUMBER_WIDTH'(s_axis_tdata_i);

  // Shared divider: number divided by the current trial divisor
  assign div_req.start    = (state_q == S_START);
  assign div_req.dividend = num_q;
  assign div_req.divisor  = dvs_q;

  pnc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Divisor pair contribution, skipping the number itself and a square root twice
  assign term_lo = (dvs_q != num_q) ? {1'b0, dvs_q} : '0;
  assign term_hi = (div_rsp.quotient != dvs_q && div_rsp.quotient != num_q) ?
                   {1'b0, div_rsp.quotient} : '0;
  assign term    = term_lo + term_hi;

  assign acc_ext  = (ACC_WIDTH + SUM_WIDTH)'(acc_q);
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    dvs_d       = dvs_q;
    acc_d       = acc_q;
    sum_out_d   = sum_out_q;
    perf_out_d  = perf_out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          num_d = in_num;
          dvs_d = NUMBER_WIDTH'(1);
          acc_d = '0;
          if (in_num < NUMBER_WIDTH'(2)) begin
            state_d = S_FIN;
          end else begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        state_d = S_RUN;
      end
      S_RUN: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient < dvs_q) begin
            state_d = S_FIN;
          end else begin
            if (div_rsp.rem_zero) begin
              acc_d = acc_q + ACC_WIDTH'(term);
            end
            dvs_d   = dvs_q + 1'b1;
            state_d = S_START;
          end
        end
      end
      S_FIN: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          sum_out_d   = (acc_ext > (ACC_WIDTH + SUM_WIDTH)'(SUM_MAX)) ?
                        SUM_MAX : acc_ext[SUM_WIDTH-1:0];
          perf_out_d  = (num_q != '0) && (acc_q == ACC_WIDTH'(num_q));
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    num_q      <= num_d;
    dvs_q      <= dvs_d;
    acc_q      <= acc_d;
    sum_out_q  <= sum_out_d;
    perf_out_q <= perf_out_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_WIDTH'({perf_out_q, sum_out_q});

  // A divider response only arrives while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_RUN)
    else $error("divider response outside run state");

  // Trial divisor never wraps to zero while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START || state_q == S_RUN) |-> dvs_q != '0)
    else $error("trial divisor is zero");

  // Leaving the finish state always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> m_axis_tvalid_o)
    else $error("result lost on finish");

  // Results are written only from the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == S_FIN)
    else $error("result appeared without finish");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  import pnc_pkg::*;

  // One pending classification, kept with the number that caused it
  typedef struct packed {
    logic [IN_TDATA_WIDTH-1:0] number;
    logic [SUM_WIDTH-1:0]      divisor_sum;
    logic                      is_perfect;
  } classification_t;

  localparam int unsigned PAD_WIDTH    = OUT_TDATA_WIDTH - SUM_WIDTH - 1;
  localparam int unsigned RANDOM_COUNT = 100;
  localparam int unsigned CALM_COUNT   = 20;
  localparam int unsigned DRAIN_CYCLES = 5000;

  logic                       clk_i = 1'b0;
  logic                       rst_n = 1'b0;
  logic [IN_TDATA_WIDTH-1:0]  s_tdata = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;

  // Idling is switched off for the last part of the run
  bit calm = 1'b0;

  classification_t pending_q[$];
  int unsigned numbers_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned perfect_seen    = 0;
  int unsigned mismatch_count  = 0;

  perfect_number_checker i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  // Free-running 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Sum proper divisors through the pairs (d, n/d) with d*d <= n
  function automatic classification_t classify_number(logic [IN_TDATA_WIDTH-1:0] number);
    classification_t  c;
    longint unsigned  n;
    longint unsigned  total;
    longint unsigned  d;
    longint unsigned  q;
    n = longint'(number) & ((64'd1 << NUMBER_WIDTH) - 64'd1);
    total = 0;
    if (n >= 2) begin
      for (d = 1; d * d <= n; d++) begin
        if (n % d == 0) begin
          q = n / d;
          if (d != n) total += d;
          if (q != d && q != n) total += q;
        end
      end
    end
    c.number      = number;
    c.divisor_sum = (total > longint'(SUM_MAX)) ? SUM_MAX : total[SUM_WIDTH-1:0];
    c.is_perfect  = (n != 0) && (total == n);
    return c;
  endfunction

  // Offer one request, optionally after a short gap; leave tvalid high afterwards
  task automatic send_number(logic [IN_TDATA_WIDTH-1:0] number);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= number;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    pending_q.push_back(classify_number(number));
    numbers_sent++;
  endtask

  task automatic test_trivial_numbers();
    send_number(16'd0);
    send_number(16'd1);
    send_number(16'd2);
    send_number(16'd3);
  endtask

  task automatic test_perfect_numbers();
    send_number(16'd6);
    send_number(16'd28);
    send_number(16'd496);
    send_number(16'd8128);
  endtask

  task automatic test_extreme_numbers();
    send_number(16'hFFFF);
    send_number(16'hFFFE);
    send_number(16'h8000);
    send_number(16'd65521);  // largest 16-bit prime
    send_number(16'd65025);  // 255 squared, root divisor counted once
    send_number(16'd49);
    send_number(16'd12);
    send_number(16'd55440);  // highly composite, large aliquot sum
    send_number(16'h5555);
    send_number(16'hAAAA);
  endtask

  // Mostly full-range numbers, some small ones; the tail runs without idling
  task automatic test_random_numbers();
    logic [IN_TDATA_WIDTH-1:0] number;
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == RANDOM_COUNT - CALM_COUNT) calm = 1'b1;
      if ($urandom_range(0, 3) == 0) number = IN_TDATA_WIDTH'($urandom_range(0, 255));
      else number = IN_TDATA_WIDTH'($urandom_range(0, 16'hFFFF));
      send_number(number);
    end
  endtask

  // Check each accepted result and pick the next tready value
  initial begin
    classification_t exp_c;
    int unsigned     stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (pending_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request pending: expected none, actual tdata 0x%06h",
                   $time, m_tdata);
        end else begin
          exp_c = pending_q.pop_front();
          if (m_tdata[SUM_WIDTH-1:0] !== exp_c.divisor_sum) begin
            mismatch_count++;
            $display("%0t: number %0d divisor_sum: expected %0d, actual %0d", $time,
                     exp_c.number, exp_c.divisor_sum, m_tdata[SUM_WIDTH-1:0]);
          end
          if (m_tdata[SUM_WIDTH] !== exp_c.is_perfect) begin
            mismatch_count++;
            $display("%0t: number %0d is_perfect: expected %0b, actual %0b", $time,
                     exp_c.number, exp_c.is_perfect, m_tdata[SUM_WIDTH]);
          end
          if (m_tdata[OUT_TDATA_WIDTH-1 -: PAD_WIDTH] !== '0) begin
            mismatch_count++;
            $display("%0t: number %0d padding: expected 0, actual 0x%0h", $time,
                     exp_c.number, m_tdata[OUT_TDATA_WIDTH-1 -: PAD_WIDTH]);
          end
          if (m_tdata[SUM_WIDTH] === 1'b1) perfect_seen++;
        end
      end
      if (calm) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #8ms;
    $display("Verification failed");
    $finish;
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_trivial_numbers();
    test_perfect_numbers();
    test_extreme_numbers();
    test_random_numbers();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Classified %0d numbers (directed edge values and random 16-bit values),",
             numbers_sent);
    $display("checked %0d results, %0d of them perfect, with %0d mismatches.",
             results_checked, perfect_seen, mismatch_count);
    if (mismatch_count == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pnc_pkg.sv
hdl/pnc_div.sv
hdl/perfect_number_checker.sv
verif/testbench.sv
